// File: src/cgen_pkg.sv
// Shared constants, register indexes and cell control type for the CRC codeword generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cgen_pkg;

  localparam int GEN_W          = 32;
  localparam int DEG_W          = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_DEGREE_DEF = 32;

  localparam logic [GEN_W-1:0] GEN_LOW_RST = 32'd7;
  localparam logic [DEG_W-1:0] DEG_RST     = 6'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GENERATOR_LOW    = 2'd0,
    REG_GENERATOR_DEGREE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic fb;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: src/crc_codeword_generator.sv
// Top level of the serial systematic CRC codeword generator.
// Depends on cgen_pkg and cgen_cell.
`timescale 1ns / 1ps
`default_nettype none

// Serial CRC encoder with a programmable generator of degree r (1..MAX_DEGREE). Message bits
// are taken one per cycle while the output is not stalled and no remainder is being
// flushed; each is passed through as a code bit while a row of cells, one per remainder
// bit, divides by the generator. After the bit marked last, the r remainder bits are shifted
// out of the cell row MSB first, one per cycle while the output is not stalled, and the input
// is held off until all of them are out. A generator with a zero constant term or an even
// number of terms yields no code bits; the last bit of the message then gives one result
// with bad_generator set. cfg_ready is always high; a write applies from the next request on.
module crc_codeword_generator
  import cgen_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_message_bit,
  input  wire logic                 in_is_last,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_code_bit,
  output logic                      out_end_of_word,
  output logic                      out_bad_generator,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [GEN_W-1:0]     cfg_data
);

  localparam int EW = $clog2(MAX_DEGREE + 1);

  logic [GEN_W-1:0]      gen_low_r;
  logic [DEG_W-1:0]      deg_r;
  logic [EW-1:0]         r_eff;
  logic [MAX_DEGREE-1:0] act;
  logic [MAX_DEGREE-1:0] topsel;
  logic [MAX_DEGREE-1:0] g_full;
  logic [MAX_DEGREE-1:0] g_m;
  logic [MAX_DEGREE-1:0] rem_q;
  logic                  bad;
  logic                  top;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_code_bit_r, out_code_bit_nxt;
  logic                  out_end_of_word_r, out_end_of_word_nxt;
  logic                  out_bad_generator_r, out_bad_generator_nxt;
  logic [EW-1:0]         cnt_r, cnt_nxt;

  logic                  adv;
  logic                  flushing;
  logic                  acc;
  cell_ctl_t             ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_low_r <= GEN_LOW_RST;
      deg_r     <= DEG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_GENERATOR_LOW:    gen_low_r <= cfg_data;
        REG_GENERATOR_DEGREE: deg_r     <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (deg_r == '0) begin
      r_eff = EW'(1);
    end else if (int'(deg_r) > MAX_DEGREE) begin
      r_eff = EW'(MAX_DEGREE);
    end else begin
      r_eff = EW'(deg_r);
    end
  end

  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_dec
    assign act[i]    = int'(r_eff) > i;
    assign topsel[i] = int'(r_eff) == i + 1;
    if (i < GEN_W) begin : g_in
      assign g_full[i] = gen_low_r[i];
    end else begin : g_out
      assign g_full[i] = 1'b0;
    end
  end

  assign g_m = g_full & act;
  assign bad = !g_m[0] || (^g_m);
  assign top = |(rem_q & topsel);

  assign adv      = !out_valid_r || out_ready;
  assign flushing = cnt_r != '0;
  assign in_ready = !flushing && adv;
  assign acc      = in_valid && in_ready;

  always_comb begin
    ctl.clear = acc && bad && in_is_last;
    ctl.shift = (acc && !bad) || (flushing && adv);
    ctl.fb    = acc && (in_message_bit ^ top);
  end

  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
    logic sin;
    if (i == 0) begin : g_first
      assign sin = 1'b0;
    end else begin : g_next
      assign sin = rem_q[i-1];
    end
    cgen_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .active   (act[i]),
      .g_bit    (g_full[i]),
      .shift_in (sin),
      .q        (rem_q[i])
    );
  end

  always_comb begin
    out_valid_nxt         = out_valid_r;
    out_code_bit_nxt      = out_code_bit_r;
    out_end_of_word_nxt   = out_end_of_word_r;
    out_bad_generator_nxt = out_bad_generator_r;
    cnt_nxt               = cnt_r;
    if (acc && !bad) begin
      out_valid_nxt         = 1'b1;
      out_code_bit_nxt      = in_message_bit;
      out_end_of_word_nxt   = 1'b0;
      out_bad_generator_nxt = 1'b0;
      if (in_is_last) begin
        cnt_nxt = r_eff;
      end
    end else if (acc && in_is_last) begin
      out_valid_nxt         = 1'b1;
      out_code_bit_nxt      = 1'b0;
      out_end_of_word_nxt   = 1'b1;
      out_bad_generator_nxt = 1'b1;
    end else if (flushing && adv) begin
      out_valid_nxt         = 1'b1;
      out_code_bit_nxt      = top;
      out_end_of_word_nxt   = cnt_r == EW'(1);
      out_bad_generator_nxt = 1'b0;
      cnt_nxt               = cnt_r - EW'(1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_bit_r      <= out_code_bit_nxt;
    out_end_of_word_r   <= out_end_of_word_nxt;
    out_bad_generator_r <= out_bad_generator_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_code_bit      = out_code_bit_r;
  assign out_end_of_word   = out_end_of_word_r;
  assign out_bad_generator = out_bad_generator_r;

endmodule

`default_nettype wire

// File: src/cgen_cell.sv
// One remainder bit of the CRC shift register.
// Depends on cgen_pkg for the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module cgen_cell
  import cgen_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire logic      active,
  input  wire logic      g_bit,
  input  wire logic      shift_in,
  output logic           q
);

  logic q_r;
  logic q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.clear) begin
      q_nxt = 1'b0;
    end else if (ctl.shift) begin
      q_nxt = active ? (shift_in ^ (ctl.fb & g_bit)) : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// File: src/cgen_checker.sv
// Port-level assertions for crc_codeword_generator, attached by bind.
// Depends on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module cgen_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_code_bit,
  input wire logic out_end_of_word,
  input wire logic out_bad_generator
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_bit)
      && $stable(out_end_of_word) && $stable(out_bad_generator))
    else $error("stalled result changed");

  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_generator |-> out_end_of_word && !out_code_bit)
    else $error("malformed error result");

  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind crc_codeword_generator cgen_checker u_cgen_checker (.*);

`default_nettype wire
